>>> hdl/ppgfc_pkg.sv
package ppgfc_pkg;

  // frame layout
  localparam int FRAME_LENGTH_DEF = 19;
  localparam logic [7:0] FRAME_MARK = 8'h05;
  localparam int PPG_HI_POS = 13;
  localparam int PPG_LO_POS = 14;
  localparam int ECG_HI_POS = 15;
  localparam int ECG_LO_POS = 16;

  // frame queue between framer and engine
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [15:0] CONTACT_LOW_RST = 16'd300;
  localparam logic [15:0] CONTACT_HIGH_RST = 16'd65000;
  localparam logic [15:0] SETTLE_MS_RST = 16'd1000;
  localparam logic [15:0] CALIB_MS_RST = 16'd5000;
  localparam logic [15:0] FLOOR_RST = 16'd100;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd4;

  // divide by five: floor(y * 0xCCCCCCCD / 2^34) is exact for any 32-bit y
  localparam int DIV_W = 27;
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 34;
  localparam int PROD_W = DIV_W + 32;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [15:0] ppg_sample;
    logic [15:0] ecg_sample;
    logic        contact_ok;
    logic [1:0]  phase;
    logic        calib_done;
    logic [23:0] baseline_out;
    logic [23:0] peak_threshold;
  } out_word_t;

  typedef struct packed {
    logic [15:0] ppg;
    logic [15:0] ecg;
    logic [31:0] stamp;
  } frame_t;

  typedef struct packed {
    logic [15:0] contact_low;
    logic [15:0] contact_high;
    logic [15:0] settle_ms;
    logic [15:0] calib_ms;
    logic [15:0] threshold_floor;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_CALIB   = 2'd1,
    PH_MEASURE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_APPLY,
    ENG_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_THRESH,
    DIV_BASE
  } div_kind_t;

endpackage

>>> hdl/ppg_frame_contact_calibrator_top.sv
// channel | dir | handshake            | word
// in      | in  | in_valid / in_ready   | in_data: rx_byte, now_ms
// out     | out | out_valid / out_ready | out_data: ppg, ecg, contact, phase, done, baseline, threshold
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// one serial byte is taken every cycle; the framer never waits except on the
// closing byte of a frame while the two-entry frame queue is full
// each frame passes the engine through decide, multiply, apply and emit, using
// the shared divide-by-five multiplier; its result is registered in the emit step
// rst is synchronous: hunting for a header, phase waiting, registers at defaults
// a result waiting on out_ready stalls the engine; bytes keep flowing until a closing byte meets a full queue
module ppg_frame_contact_calibrator_top #(
  parameter int FRAME_LENGTH = ppgfc_pkg::FRAME_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ppgfc_pkg::in_word_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ppgfc_pkg::out_word_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppgfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data
);
  import ppgfc_pkg::*;

  cfg_t      cfg;
  logic      q_push;
  frame_t    q_wr_data;
  logic      q_pop;
  frame_t    q_rd_data;
  q_status_t q_status;

  // register bank, writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contact_low     <= CONTACT_LOW_RST;
      cfg.contact_high    <= CONTACT_HIGH_RST;
      cfg.settle_ms       <= SETTLE_MS_RST;
      cfg.calib_ms        <= CALIB_MS_RST;
      cfg.threshold_floor <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONTACT_LOW:  cfg.contact_low     <= cfg_data;
        CFG_CONTACT_HIGH: cfg.contact_high    <= cfg_data;
        CFG_SETTLE_MS:    cfg.settle_ms       <= cfg_data;
        CFG_CALIB_MS:     cfg.calib_ms        <= cfg_data;
        CFG_FLOOR:        cfg.threshold_floor <= cfg_data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // front: header hunt and frame assembly
  ppgfc_framer #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_framer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (q_push),
    .push_data(q_wr_data),
    .q_status (q_status)
  );

  // short queue of completed frames
  ppgfc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data(q_wr_data),
    .pop    (q_pop),
    .rd_data(q_rd_data),
    .status (q_status)
  );

  // back: contact check, phase machine, baseline and threshold
  ppgfc_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // the framer must never push a frame into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("frame pushed into full queue");

  // calibration ends by moving to measuring
  a_done_measuring: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.calib_done) |-> (out_data.phase == PH_MEASURE))
    else $error("calib_done outside measuring phase");

  // lost contact always drops back to waiting
  a_no_contact_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.contact_ok) |-> (out_data.phase == PH_WAIT))
    else $error("phase not waiting without contact");

  // the engine only pops a frame that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> hdl/ppgfc_framer.sv
module ppgfc_framer #(
  parameter int FRAME_LENGTH = ppgfc_pkg::FRAME_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppgfc_pkg::in_word_t in_data,
  output logic                push,
  output ppgfc_pkg::frame_t   push_data,
  input  ppgfc_pkg::q_status_t q_status
);
  import ppgfc_pkg::*;

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  logic [POS_W-1:0] frame_pos;
  logic [15:0]      ppg_word;
  logic [15:0]      ecg_word;
  logic [15:0]      ppg_cur;
  logic [15:0]      ecg_cur;
  logic             accept;
  logic             last_byte;

  assign last_byte = (frame_pos == LAST_POS);
  // only the closing byte of a frame needs queue space
  assign in_ready  = !(last_byte && q_status.full);
  assign accept    = in_valid && in_ready;

  // fold the current byte into the words
  always_comb begin
    ppg_cur = ppg_word;
    ecg_cur = ecg_word;
    case (frame_pos)
      POS_W'(PPG_HI_POS): ppg_cur = {in_data.rx_byte, ppg_word[7:0]};
      POS_W'(PPG_LO_POS): ppg_cur = {ppg_word[15:8], in_data.rx_byte};
      POS_W'(ECG_HI_POS): ecg_cur = {in_data.rx_byte, ecg_word[7:0]};
      POS_W'(ECG_LO_POS): ecg_cur = {ecg_word[15:8], in_data.rx_byte};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
    end else if (accept) begin
      if (frame_pos == '0) begin
        if (in_data.rx_byte == FRAME_MARK) begin
          frame_pos <= POS_W'(1);
        end
      end else if (last_byte) begin
        frame_pos <= '0;
      end else begin
        frame_pos <= frame_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ppg_word <= ppg_cur;
      ecg_word <= ecg_cur;
    end
  end

  assign push            = accept && last_byte;
  assign push_data.ppg   = ppg_cur;
  assign push_data.ecg   = ecg_cur;
  assign push_data.stamp = in_data.now_ms;

endmodule

>>> hdl/ppgfc_fifo.sv
module ppgfc_fifo #(
  parameter int DEPTH = ppgfc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ppgfc_pkg::frame_t     wr_data,
  input  logic                  pop,
  output ppgfc_pkg::frame_t     rd_data,
  output ppgfc_pkg::q_status_t  status
);
  import ppgfc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> hdl/ppgfc_engine.sv
module ppgfc_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  ppgfc_pkg::cfg_t      cfg,
  input  ppgfc_pkg::q_status_t q_status,
  input  ppgfc_pkg::frame_t    q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppgfc_pkg::out_word_t out_data
);
  import ppgfc_pkg::*;

  eng_state_t state;
  eng_state_t state_next;
  logic       load_out;

  phase_t      fsm_phase;
  logic        contact_timing;
  logic [31:0] contact_start;
  logic [31:0] calib_start;
  logic [15:0] calib_min;
  logic [15:0] calib_max;
  logic [23:0] baseline;
  logic [23:0] threshold;

  div_kind_t         div_kind;
  logic [DIV_W-1:0]  dividend;
  logic [PROD_W-1:0] product;
  logic [15:0]       ppg_r;
  logic [15:0]       ecg_r;
  logic              ok_r;
  logic              done_r;

  logic        ok;
  logic [31:0] since_contact;
  logic [31:0] since_calib;
  logic [15:0] new_min;
  logic [15:0] new_max;
  logic [15:0] amp;
  logic [24:0] th_num;
  logic [16:0] mid_sum;
  logic [28:0] meas_sum;
  logic [23:0] quot;
  logic [23:0] floor_fx;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE:  if (!q_status.empty) state_next = ENG_MUL;
      ENG_MUL:   state_next = ENG_APPLY;
      ENG_APPLY: state_next = ENG_EMIT;
      ENG_EMIT:  if (!out_valid || out_ready) state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      ENG_IDLE: q_pop = !q_status.empty;
      ENG_EMIT: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame decisions
  assign ok            = (q_data.ppg >= cfg.contact_low) && (q_data.ppg <= cfg.contact_high);
  assign since_contact = q_data.stamp - contact_start;
  assign since_calib   = q_data.stamp - calib_start;
  assign new_min       = (q_data.ppg < calib_min) ? q_data.ppg : calib_min;
  assign new_max       = (q_data.ppg > calib_max) ? q_data.ppg : calib_max;
  assign amp           = (new_max >= new_min) ? (new_max - new_min) : 16'd0;
  // amp * 448 + 2, later divided by five
  assign th_num        = {amp, 9'd0} - {3'd0, amp, 6'd0} + 25'd2;
  assign mid_sum       = {1'b0, new_min} + {1'b0, new_max};
  // 19 * baseline + 256 * ppg + 10, divided by four here and by five later
  assign meas_sum      = {1'b0, baseline, 4'd0} + {4'd0, baseline, 1'b0} + 29'(baseline)
                         + 29'({q_data.ppg, 8'd0}) + 29'd10;
  assign quot          = product[RECIP_SHIFT +: 24];
  assign floor_fx      = {cfg.threshold_floor, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_phase      <= PH_WAIT;
      contact_timing <= 1'b0;
      contact_start  <= '0;
      calib_start    <= '0;
      calib_min      <= 16'hFFFF;
      calib_max      <= '0;
      baseline       <= '0;
      threshold      <= '0;
      div_kind       <= DIV_NONE;
    end else if (q_pop) begin
      div_kind <= DIV_NONE;
      if (!ok) begin
        contact_timing <= 1'b0;
        fsm_phase      <= PH_WAIT;
      end else begin
        case (fsm_phase)
          PH_WAIT: begin
            if (!contact_timing) begin
              contact_timing <= 1'b1;
              contact_start  <= q_data.stamp;
            end else if (since_contact >= {16'd0, cfg.settle_ms}) begin
              fsm_phase   <= PH_CALIB;
              calib_start <= q_data.stamp;
              calib_min   <= 16'hFFFF;
              calib_max   <= '0;
            end
          end
          PH_CALIB: begin
            calib_min <= new_min;
            calib_max <= new_max;
            if (since_calib >= {16'd0, cfg.calib_ms}) begin
              baseline  <= {mid_sum, 7'd0};
              div_kind  <= DIV_THRESH;
              fsm_phase <= PH_MEASURE;
            end
          end
          PH_MEASURE: div_kind <= DIV_BASE;
          default: ;
        endcase
      end
    end else if (state == ENG_APPLY) begin
      case (div_kind)
        DIV_THRESH: threshold <= (quot < floor_fx) ? floor_fx : quot;
        DIV_BASE:   baseline <= quot;
        default: ;
      endcase
    end
  end

  // frame payload and the shared divide-by-five multiplier
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ppg_r    <= q_data.ppg;
      ecg_r    <= q_data.ecg;
      ok_r     <= ok;
      done_r   <= ok && (fsm_phase == PH_CALIB) && (since_calib >= {16'd0, cfg.calib_ms});
      dividend <= (fsm_phase == PH_CALIB) ? DIV_W'(th_num) : meas_sum[28:2];
    end
    if (state == ENG_MUL) begin
      product <= PROD_W'(dividend) * PROD_W'(RECIP5);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.ppg_sample     <= ppg_r;
      out_data.ecg_sample     <= ecg_r;
      out_data.contact_ok     <= ok_r;
      out_data.phase          <= fsm_phase;
      out_data.calib_done     <= done_r;
      out_data.baseline_out   <= baseline;
      out_data.peak_threshold <= threshold;
    end
  end

endmodule
